@@ rtl/core/ecr_pkg.sv @@
// Shared types, widths and codes for the elastic collision response block.
package ecr_pkg;

   localparam int VAL_W       = 32;  // signed Q16.16 position and velocity
   localparam int MASS_W      = 32;  // unsigned Q16.16 mass
   localparam int CSR_IDX_W   = 8;
   localparam int NORM_BITS   = 28;  // normal vector is Q2.28
   localparam int SCALE_TOP   = 29;  // largest scaled magnitude has its top bit here
   localparam int DIFF_W      = 33;  // |p2 - p1|
   localparam int POS_W       = 6;   // bit position within DIFF_W
   localparam int SMAG_W      = SCALE_TOP + 1;
   localparam int SQ_W        = 2 * SMAG_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int LEN_W       = SUM_W / 2;
   localparam int REM_W       = LEN_W + 1;
   localparam int QUO_W       = NORM_BITS + 1;
   localparam int NRM_W       = QUO_W + 1;
   localparam int DV_W        = VAL_W + 1;
   localparam int PROD_W      = DV_W + NRM_W;
   localparam int PROJ_W      = 64;
   localparam int SPEED_W     = SUM_W - NORM_BITS;   // closing speed, Q16.16
   localparam int RATIO_W     = NORM_BITS;           // mass ratio, Q0.28
   localparam int MW_W        = SPEED_W + RATIO_W;
   localparam int IMP_W       = MW_W - (NORM_BITS - 1);
   localparam int SCL_W       = IMP_W + QUO_W;
   localparam int DELTA_W     = SCL_W - NORM_BITS;
   localparam int OUT_ACC_W   = DELTA_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int RATIO_STEPS = NORM_BITS;
   localparam int RCNT_W      = 5;

   localparam logic [MASS_W-1:0]  MASS_RESET  = MASS_W'(65536);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << (RATIO_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MASS_FIRST  = 8'd0,
      REG_MASS_SECOND = 8'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      OUTCOME_APPLIED    = 2'd0,
      OUTCOME_SEPARATING = 2'd1,
      OUTCOME_COINCIDENT = 2'd2
   } outcome_type;

   // element 0 is the x component and sits in the lowest bits
   typedef logic [2:0][VAL_W-1:0] vec_type;

   // packed struct: last member lowest, so pos1 sits in the low bits
   typedef struct packed {
      vec_type vel2;
      vec_type pos2;
      vec_type vel1;
      vec_type pos1;
   } req_item_type;

   typedef struct packed {
      vec_type vel2;
      vec_type vel1;
   } rsp_item_type;

   typedef struct packed {
      vec_type    v1;
      vec_type    v2;
      logic [2:0] neg;
      logic       coinc;
   } carry_type;

   typedef struct packed {
      carry_type                 c;
      logic [2:0][SMAG_W-1:0]    mag;
   } front_item_type;

   typedef struct packed {
      logic               busy;
      logic [RATIO_W-1:0] r1;
      logic [RATIO_W-1:0] r2;
   } ratio_status_type;

   localparam int REQ_W = $bits(req_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   function automatic logic [POS_W-1:0] top_bit(input logic [DIFF_W-1:0] x);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (x[i]) p = POS_W'(i);
      end
      return p;
   endfunction

endpackage

@@ rtl/core/elastic_collision_response.sv @@
// Top level of the elastic collision response block.
//
// One req_ item carries two bodies' positions and velocities (signed Q16.16);
// one rsp_ item comes back for each, with both new velocities and an outcome
// in rsp_tuser: response applied, bodies separating or resting, or positions
// coincident (the last two echo the input velocities unchanged).
// The csr_ channel writes the two masses (index 0 first body, 1 second body,
// unsigned Q16.16); other indices are accepted and dropped. Write only while
// no item is in flight.
// Throughput: one item per cycle while rsp_tready is high and the ratio divider
// is idle; items pass a 31-stage square root and a 29-stage normal divider.
// After a mass write the serial ratio divider runs, and while it runs
// req_tready and csr_ready stay low.
// Reset clears all valid state and loads both masses with 1.0.
// When the receiver stalls, the back end holds; the front end keeps accepting
// into a four-entry queue and stops only when that is full.
module elastic_collision_response import ecr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // first_pos_x/y/z, first_vel_x/y/z, second_pos_x/y/z, second_vel_x/y/z
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // new_first_vel_x/y/z, new_second_vel_x/y/z
   output logic [RSP_W-1:0]     rsp_tdata,
   // outcome
   output logic [1:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASS_W-1:0]    csr_data
);

   ratio_status_type status;
   req_item_type     req_item;
   logic             front_in_valid, front_in_ready;
   logic             front_valid, front_ready;
   front_item_type   front_item;
   logic             queue_valid, queue_ready;
   front_item_type   queue_item;
   rsp_item_type     rsp_item;
   outcome_type      outcome;

   // hold the input side while the mass ratios are being recomputed
   assign req_item       = req_tdata;
   assign front_in_valid = req_tvalid && !status.busy;
   assign req_tready     = front_in_ready && !status.busy;

   ecr_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status)
   );

   ecr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_in_valid),
      .in_ready  (front_in_ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   ecr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   ecr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_item     (queue_item),
      .ratio1      (status.r1),
      .ratio2      (status.r2),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_item),
      .out_outcome (outcome)
   );

   assign rsp_tdata = rsp_item;
   assign rsp_tuser = outcome;

endmodule

@@ rtl/core/ecr_front.sv @@
// Front end: accept an item, take position differences and scale them.
module ecr_front import ecr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  req_item_type   in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output front_item_type out_item
);

   logic                   a_valid_ff, a_valid_in;
   carry_type              a_carry_ff, a_carry_in;
   logic [2:0][DIFF_W-1:0] a_mag_ff, a_mag_in;
   logic                   b_valid_ff, b_valid_in;
   front_item_type         b_item_ff, b_item_in;
   logic                   a_ready, b_ready;
   logic signed [DIFF_W-1:0] diff [3];
   logic [DIFF_W-1:0]      any_mag;
   logic [POS_W-1:0]       top;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_carry_in.v1    = in_item.vel1;
      a_carry_in.v2    = in_item.vel2;
      a_carry_in.coinc = 1'b0;
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed({in_item.pos2[i][VAL_W-1], in_item.pos2[i]})
                 - $signed({in_item.pos1[i][VAL_W-1], in_item.pos1[i]});
         a_carry_in.neg[i] = diff[i][DIFF_W-1];
         a_mag_in[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
      end
   end

   // top bit of the largest magnitude equals the top bit of their OR
   always_comb begin
      any_mag = a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2];
      top     = top_bit(any_mag);
      b_item_in.c       = a_carry_ff;
      b_item_in.c.coinc = (any_mag == '0);
      for (int i = 0; i < 3; i++) begin
         if (top > POS_W'(SCALE_TOP)) begin
            b_item_in.mag[i] = SMAG_W'(a_mag_ff[i] >> (top - POS_W'(SCALE_TOP)));
         end else begin
            b_item_in.mag[i] = SMAG_W'(a_mag_ff[i]) << (POS_W'(SCALE_TOP) - top);
         end
      end
   end

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_carry_ff <= a_carry_in;
         a_mag_ff   <= a_mag_in;
      end
      if (b_ready) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

@@ rtl/core/ecr_queue.sv @@
// Short queue that decouples the front end from the back end.
module ecr_queue import ecr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  front_item_type in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output front_item_type out_item
);

   front_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

@@ rtl/core/ecr_ratio.sv @@
// Mass registers and the serial divider that derives the two mass ratios.
module ecr_ratio import ecr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASS_W-1:0]    csr_data,
   output ratio_status_type     status
);

   logic [MASS_W-1:0]  m1_ff, m1_in, m2_ff, m2_in, m1_eff, m2_eff;
   logic               load_ff, load_in;
   logic [RCNT_W-1:0]  cnt_ff, cnt_in;
   logic [MASS_W:0]    total_ff, total_in, rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [RATIO_W-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [MASS_W+1:0]  t1, t2;
   logic               ge1, ge2, wr, busy;

   assign busy      = load_ff || (cnt_ff != '0);
   assign csr_ready = !busy;
   assign wr        = csr_valid && csr_ready;

   // a zero mass reads as the smallest nonzero mass
   assign m1_eff = (m1_ff == '0) ? MASS_W'(1) : m1_ff;
   assign m2_eff = (m2_ff == '0) ? MASS_W'(1) : m2_ff;

   always_comb begin
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      load_in  = 1'b0;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      rem1_in  = rem1_ff;
      rem2_in  = rem2_ff;
      q1_in    = q1_ff;
      q2_in    = q2_ff;
      t1       = {rem1_ff, 1'b0};
      t2       = {rem2_ff, 1'b0};
      ge1      = (t1 >= {1'b0, total_ff});
      ge2      = (t2 >= {1'b0, total_ff});
      if (wr && csr_index == REG_MASS_FIRST) begin
         m1_in   = csr_data;
         load_in = 1'b1;
      end
      if (wr && csr_index == REG_MASS_SECOND) begin
         m2_in   = csr_data;
         load_in = 1'b1;
      end
      if (load_ff) begin
         total_in = {1'b0, m1_eff} + {1'b0, m2_eff};
         rem1_in  = {1'b0, m1_eff};
         rem2_in  = {1'b0, m2_eff};
         q1_in    = '0;
         q2_in    = '0;
         cnt_in   = RCNT_W'(RATIO_STEPS);
      end else if (cnt_ff != '0) begin
         rem1_in = ge1 ? (MASS_W+1)'(t1 - {1'b0, total_ff}) : (MASS_W+1)'(t1);
         rem2_in = ge2 ? (MASS_W+1)'(t2 - {1'b0, total_ff}) : (MASS_W+1)'(t2);
         q1_in   = {q1_ff[RATIO_W-2:0], ge1};
         q2_in   = {q2_ff[RATIO_W-2:0], ge2};
         cnt_in  = cnt_ff - RCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff   <= MASS_RESET;
         m2_ff   <= MASS_RESET;
         load_ff <= 1'b0;
         cnt_ff  <= '0;
         q1_ff   <= RATIO_RESET;
         q2_ff   <= RATIO_RESET;
      end else begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         load_ff <= load_in;
         cnt_ff  <= cnt_in;
         q1_ff   <= q1_in;
         q2_ff   <= q2_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      rem1_ff  <= rem1_in;
      rem2_ff  <= rem2_in;
   end

   assign status.busy = busy;
   assign status.r1   = q1_ff;
   assign status.r2   = q2_ff;

endmodule

@@ rtl/core/ecr_back.sv @@
// Back end: square root, normalisation, projection and velocity exchange.
module ecr_back import ecr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  front_item_type     in_item,
   input  logic [RATIO_W-1:0] ratio1,
   input  logic [RATIO_W-1:0] ratio2,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_item_type       out_data,
   output outcome_type        out_outcome
);

   localparam int SQRT_STEPS = LEN_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int NSTAGE     = SQRT_STEPS + DIV_STEPS + 7;
   localparam int TRIAL_W    = SUM_W + 2;

   typedef struct packed {
      carry_type              c;
      logic [2:0][SMAG_W-1:0] mag;
      logic [SUM_W-1:0]       rem;
      logic [LEN_W-1:0]       root;
   } sqrt_type;

   typedef struct packed {
      carry_type             c;
      logic [2:0][REM_W-1:0] r;
      logic [2:0][QUO_W-1:0] q;
      logic [LEN_W-1:0]      len;
   } div_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s, input int k);
      sqrt_type           o;
      logic [TRIAL_W-1:0] trial;
      o = s;
      trial = (TRIAL_W'(s.root) << (k + 1)) + (TRIAL_W'(1) << (2 * k));
      if (TRIAL_W'(s.rem) >= trial) begin
         o.rem  = SUM_W'(TRIAL_W'(s.rem) - trial);
         o.root = s.root | (LEN_W'(1) << k);
      end
      return o;
   endfunction

   function automatic div_type div_step(input div_type s);
      div_type          o;
      logic             ge;
      logic [REM_W-1:0] rr;
      o = s;
      for (int i = 0; i < 3; i++) begin
         ge      = (s.r[i] >= REM_W'(s.len));
         rr      = ge ? s.r[i] - REM_W'(s.len) : s.r[i];
         o.r[i]  = rr << 1;
         o.q[i]  = {s.q[i][QUO_W-2:0], ge};
      end
      return o;
   endfunction

   function automatic logic [VAL_W-1:0] saturate(input logic [OUT_ACC_W-1:0] x);
      logic [VAL_W-1:0] r;
      if (!x[OUT_ACC_W-1] && (|x[OUT_ACC_W-2:VAL_W-1])) begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (x[OUT_ACC_W-1] && !(&x[OUT_ACC_W-2:VAL_W-1])) begin
         r = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         r = x[VAL_W-1:0];
      end
      return r;
   endfunction

   logic                    adv;
   logic [NSTAGE-1:0]       vld_ff, vld_in;

   carry_type               s1_carry_ff, s2_carry_ff;
   logic [2:0][SMAG_W-1:0]  s1_mag_ff, s2_mag_ff;
   logic [2:0][SQ_W-1:0]    s1_sq_ff, s1_sq_in;
   logic [SUM_W-1:0]        s2_sum_ff, s2_sum_in;

   sqrt_type                sq_start;
   sqrt_type                sq_ff [SQRT_STEPS];
   sqrt_type                sq_in [SQRT_STEPS];
   div_type                 dv_start;
   div_type                 dv_ff [DIV_STEPS];
   div_type                 dv_in [DIV_STEPS];

   logic signed [DV_W-1:0]   dvel [3];
   logic signed [NRM_W-1:0]  nrm [3];
   carry_type                p1_carry_ff, p2_carry_ff, r1_carry_ff, r2_carry_ff;
   logic [2:0][QUO_W-1:0]    p1_q_ff, p2_q_ff, r1_q_ff;
   logic signed [PROD_W-1:0] p1_prod_ff [3];
   logic signed [PROD_W-1:0] p1_prod_in [3];
   logic signed [PROJ_W-1:0] p2_proj_ff, p2_proj_in;
   logic [SPEED_W-1:0]       speed;
   outcome_type              r1_outcome_ff, r1_outcome_in, r2_outcome_ff;
   logic [MW_W-1:0]          r1_mw1_ff, r1_mw1_in, r1_mw2_ff, r1_mw2_in;
   logic [IMP_W-1:0]         imp1, imp2;
   logic [2:0][SCL_W-1:0]    r2_sc1_ff, r2_sc1_in, r2_sc2_ff, r2_sc2_in;
   logic [OUT_ACC_W-1:0]     acc1, acc2, vx1, vx2, dx1, dx2;
   rsp_item_type             o_data_ff, o_data_in;
   outcome_type              o_outcome_ff;

   // every stage moves together; hold everything while the result waits
   assign adv       = !vld_ff[NSTAGE-1] || out_ready;
   assign in_ready  = adv;
   assign vld_in    = adv ? {vld_ff[NSTAGE-2:0], in_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // squares and their sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_sq_in[i] = SQ_W'(in_item.mag[i]) * SQ_W'(in_item.mag[i]);
      end
      s2_sum_in = SUM_W'(s1_sq_ff[0]) + SUM_W'(s1_sq_ff[1]) + SUM_W'(s1_sq_ff[2]);
   end

   // square root, one result bit a stage
   always_comb begin
      sq_start.c    = s2_carry_ff;
      sq_start.mag  = s2_mag_ff;
      sq_start.rem  = s2_sum_ff;
      sq_start.root = '0;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      if (j == 0) begin : g_first
         assign sq_in[j] = sqrt_step(sq_start, LEN_W - 1);
      end else begin : g_next
         assign sq_in[j] = sqrt_step(sq_ff[j-1], LEN_W - 1 - j);
      end
   end

   // three restoring dividers in step, one quotient bit a stage
   always_comb begin
      dv_start.c   = sq_ff[SQRT_STEPS-1].c;
      dv_start.len = sq_ff[SQRT_STEPS-1].root;
      dv_start.q   = '0;
      for (int i = 0; i < 3; i++) begin
         dv_start.r[i] = REM_W'(sq_ff[SQRT_STEPS-1].mag[i]);
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      if (j == 0) begin : g_first
         assign dv_in[j] = div_step(dv_start);
      end else begin : g_next
         assign dv_in[j] = div_step(dv_ff[j-1]);
      end
   end

   // projection of the relative velocity onto the normal
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvel[i] = $signed({dv_ff[DIV_STEPS-1].c.v1[i][VAL_W-1], dv_ff[DIV_STEPS-1].c.v1[i]})
                 - $signed({dv_ff[DIV_STEPS-1].c.v2[i][VAL_W-1], dv_ff[DIV_STEPS-1].c.v2[i]});
         nrm[i]  = dv_ff[DIV_STEPS-1].c.neg[i] ? -$signed({1'b0, dv_ff[DIV_STEPS-1].q[i]})
                                               : $signed({1'b0, dv_ff[DIV_STEPS-1].q[i]});
         p1_prod_in[i] = dvel[i] * nrm[i];
      end
      p2_proj_in = p1_prod_ff[0] + p1_prod_ff[1] + p1_prod_ff[2];
   end

   // classify, then closing speed times mass ratios
   always_comb begin
      priority if (p2_carry_ff.coinc) begin
         r1_outcome_in = OUTCOME_COINCIDENT;
      end else if (p2_proj_ff[PROJ_W-1] || p2_proj_ff == '0) begin
         r1_outcome_in = OUTCOME_SEPARATING;
      end else begin
         r1_outcome_in = OUTCOME_APPLIED;
      end
      speed     = p2_proj_ff[NORM_BITS+SPEED_W-1:NORM_BITS];
      r1_mw1_in = MW_W'(speed) * MW_W'(ratio2);
      r1_mw2_in = MW_W'(speed) * MW_W'(ratio1);
   end

   // impulses (twice the product, back to Q16.16) along each normal component
   always_comb begin
      imp1 = r1_mw1_ff[MW_W-1:NORM_BITS-1];
      imp2 = r1_mw2_ff[MW_W-1:NORM_BITS-1];
      for (int i = 0; i < 3; i++) begin
         r2_sc1_in[i] = SCL_W'(imp1) * SCL_W'(r1_q_ff[i]);
         r2_sc2_in[i] = SCL_W'(imp2) * SCL_W'(r1_q_ff[i]);
      end
   end

   // apply the exchange and saturate; echo the inputs otherwise
   always_comb begin
      acc1 = '0;
      acc2 = '0;
      vx1  = '0;
      vx2  = '0;
      dx1  = '0;
      dx2  = '0;
      for (int i = 0; i < 3; i++) begin
         vx1  = {{(OUT_ACC_W-VAL_W){r2_carry_ff.v1[i][VAL_W-1]}}, r2_carry_ff.v1[i]};
         vx2  = {{(OUT_ACC_W-VAL_W){r2_carry_ff.v2[i][VAL_W-1]}}, r2_carry_ff.v2[i]};
         dx1  = OUT_ACC_W'(r2_sc1_ff[i][SCL_W-1:NORM_BITS]);
         dx2  = OUT_ACC_W'(r2_sc2_ff[i][SCL_W-1:NORM_BITS]);
         acc1 = r2_carry_ff.neg[i] ? vx1 + dx1 : vx1 - dx1;
         acc2 = r2_carry_ff.neg[i] ? vx2 - dx2 : vx2 + dx2;
         if (r2_outcome_ff == OUTCOME_APPLIED) begin
            o_data_in.vel1[i] = saturate(acc1);
            o_data_in.vel2[i] = saturate(acc2);
         end else begin
            o_data_in.vel1[i] = r2_carry_ff.v1[i];
            o_data_in.vel2[i] = r2_carry_ff.v2[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_carry_ff <= in_item.c;
         s1_mag_ff   <= in_item.mag;
         s1_sq_ff    <= s1_sq_in;
         s2_carry_ff <= s1_carry_ff;
         s2_mag_ff   <= s1_mag_ff;
         s2_sum_ff   <= s2_sum_in;
         for (int j = 0; j < SQRT_STEPS; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[j] <= dv_in[j];
         end
         p1_carry_ff <= dv_ff[DIV_STEPS-1].c;
         p1_q_ff     <= dv_ff[DIV_STEPS-1].q;
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= p1_prod_in[i];
         end
         p2_carry_ff   <= p1_carry_ff;
         p2_q_ff       <= p1_q_ff;
         p2_proj_ff    <= p2_proj_in;
         r1_carry_ff   <= p2_carry_ff;
         r1_q_ff       <= p2_q_ff;
         r1_outcome_ff <= r1_outcome_in;
         r1_mw1_ff     <= r1_mw1_in;
         r1_mw2_ff     <= r1_mw2_in;
         r2_carry_ff   <= r1_carry_ff;
         r2_outcome_ff <= r1_outcome_ff;
         r2_sc1_ff     <= r2_sc1_in;
         r2_sc2_ff     <= r2_sc2_in;
         o_data_ff     <= o_data_in;
         o_outcome_ff  <= r2_outcome_ff;
      end
   end

   assign out_valid   = vld_ff[NSTAGE-1];
   assign out_data    = o_data_ff;
   assign out_outcome = o_outcome_ff;

endmodule

@@ dv/elastic_collision_response_tb.sv @@
// Self-checking testbench for the elastic collision response block.
module elastic_collision_response_tb;
   import ecr_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES  = 100;   // longer than the full pipeline
   localparam int SETTLE_CYCLES = 80;    // before a mass write
   localparam int PHASE_ITEMS   = 175;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 8'd7;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VAL_W-1:0] ONE     = 32'h0001_0000;

   typedef struct packed {
      rsp_item_type vel;
      outcome_type  oc;
   } velocity_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MASS_W-1:0] csr_data = '0;

   logic [MASS_W-1:0] mass_a = MASS_RESET;
   logic [MASS_W-1:0] mass_b = MASS_RESET;
   velocity_result_type pending_velocities[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   elastic_collision_response uut (.*);

   always #HALF_PERIOD clock = ~clock;

   // ---------------- predictor ----------------

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] res, bit_w;
      res = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > s) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (s >= res + bit_w) begin
            s = s - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic [VAL_W-1:0] saturate(input longint x);
      if (x > longint'(2147483647)) return VAL_MAX;
      if (x < -longint'(2147483647) - 1) return VAL_MIN;
      return x[VAL_W-1:0];
   endfunction

   // sign(n) * floor(mag * |n| / 2^28)
   function automatic longint along_normal(input logic [63:0] mag, input longint n);
      logic [63:0] an, q;
      an = (n < 0) ? 64'(-n) : 64'(n);
      q = (mag * an) >> NORM_BITS;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic velocity_result_type collide(input req_item_type it);
      velocity_result_type r;
      longint d, proj, v1, v2;
      logic [63:0] mag[3];
      logic [63:0] big, sum, len, m1, m2, total, r1, r2, w, j1, j2;
      logic [2:0] neg;
      longint n[3];
      r.vel.vel1 = it.vel1;
      r.vel.vel2 = it.vel2;
      big = '0;
      for (int i = 0; i < 3; i++) begin
         d = longint'($signed(it.pos2[i])) - longint'($signed(it.pos1[i]));
         neg[i] = d < 0;
         mag[i] = neg[i] ? 64'(-d) : 64'(d);
         if (mag[i] > big) big = mag[i];
      end
      if (big == 0) begin
         r.oc = OUTCOME_COINCIDENT;
         return r;
      end
      // bring the largest magnitude's top bit to bit 29
      while (big >= (64'd1 << (SCALE_TOP + 1))) begin
         big = big >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (big < (64'd1 << SCALE_TOP)) begin
         big = big << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      sum = '0;
      for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
      len = int_sqrt(sum);
      proj = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = longint'((mag[i] << NORM_BITS) / len);
         if (neg[i]) n[i] = -n[i];
         proj = proj + longint'($signed(it.vel1[i])) * n[i]
                     - longint'($signed(it.vel2[i])) * n[i];
      end
      if (proj <= 0) begin
         r.oc = OUTCOME_SEPARATING;
         return r;
      end
      // a zero mass counts as the smallest nonzero one
      m1 = (mass_a == 0) ? 64'd1 : 64'(mass_a);
      m2 = (mass_b == 0) ? 64'd1 : 64'(mass_b);
      total = m1 + m2;
      r1 = (m1 << NORM_BITS) / total;
      r2 = (m2 << NORM_BITS) / total;
      w = 64'(proj) >> NORM_BITS;
      j1 = (64'd2 * w * r2) >> NORM_BITS;
      j2 = (64'd2 * w * r1) >> NORM_BITS;
      for (int i = 0; i < 3; i++) begin
         v1 = longint'($signed(it.vel1[i]));
         v2 = longint'($signed(it.vel2[i]));
         r.vel.vel1[i] = saturate(v1 - along_normal(j1, n[i]));
         r.vel.vel2[i] = saturate(v2 + along_normal(j2, n[i]));
      end
      r.oc = OUTCOME_APPLIED;
      return r;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      velocity_result_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_velocities.size() == 0) begin
            report_mismatch("unexpected item", {got.vel1[0], got.vel2[0]}, '0);
         end else begin
            want = pending_velocities.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (got.vel1[i] !== want.vel.vel1[i])
                  report_mismatch($sformatf("new_first_vel[%0d]", i), got.vel1[i],
                                  want.vel.vel1[i]);
               if (got.vel2[i] !== want.vel.vel2[i])
                  report_mismatch($sformatf("new_second_vel[%0d]", i), got.vel2[i],
                                  want.vel.vel2[i]);
            end
            if (rsp_tuser !== want.oc)
               report_mismatch("outcome", rsp_tuser, want.oc);
         end
      end
   end

   // watchdog: any handshake resets the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver back-pressure by time and idle count, calm stretch included
   always @(negedge clock) begin
      int unsigned cyc;
      cyc = $urandom_range(0, 99);
      case ((idle_cycles + $time / 2560) % 4)
         0: rsp_tready = 1'b1;
         1: rsp_tready = cyc < 70;
         2: rsp_tready = (($time / 10) % 7) != 0;
         default: rsp_tready = cyc < 30;
      endcase
   end

   // ---------------- drivers ----------------

   // send one item; return at the edge where it was taken
   task automatic send_item(input req_item_type it);
      @(negedge clock);
      if (burst_left == 0) begin
         // hold off for a random gap, then start a new burst
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = it;
      do @(posedge clock); while (!req_tready);
      pending_velocities = {pending_velocities, collide(it)};
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_velocities.size() != 0) @(negedge clock);
   endtask

   task automatic write_mass(input logic [CSR_IDX_W-1:0] idx, input logic [MASS_W-1:0] val);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_MASS_FIRST) mass_a = val;
      else if (idx == REG_MASS_SECOND) mass_b = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------- stimulus ----------------

   function automatic logic [VAL_W-1:0] near(input logic [VAL_W-1:0] base, input int span);
      return base + VAL_W'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic req_item_type random_pair();
      req_item_type it;
      int unsigned mode;
      int span;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         it.pos1[i] = $urandom;
         it.pos2[i] = $urandom;
         it.vel1[i] = $urandom;
         it.vel2[i] = $urandom;
      end
      if (mode == 0) begin
         it.pos2 = it.pos1;
      end else if (mode <= 7) begin
         // nearby bodies; in modes below 6 the first heads towards the second
         span = (mode < 4) ? 16 : 65536 * $urandom_range(1, 64);
         for (int i = 0; i < 3; i++) begin
            it.pos1[i] = $urandom_range(0, 1) ? $urandom : VAL_W'($urandom_range(0, 1 << 20));
            it.pos2[i] = near(it.pos1[i], span);
            if (mode < 6) begin
               it.vel1[i] = VAL_W'($signed(it.pos2[i] - it.pos1[i]) >>> $urandom_range(0, 8));
               it.vel2[i] = near(VAL_W'(0), 1 << $urandom_range(0, 24));
            end
         end
      end
      return it;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_item(random_pair());
   endtask

   function automatic req_item_type make_pair(input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] vx,
                                              input logic [VAL_W-1:0] qx, input logic [VAL_W-1:0] wx);
      req_item_type it;
      it = '0;
      it.pos1[0] = px;
      it.vel1[0] = vx;
      it.pos2[0] = qx;
      it.vel2[0] = wx;
      return it;
   endfunction

   task automatic test_directed();
      req_item_type it;
      send_item(make_pair('0, ONE, '0, -ONE));                  // coincident
      send_item(make_pair('0, ONE, ONE, -ONE));                 // head-on along x
      send_item(make_pair('0, -ONE, ONE, ONE));                 // separating
      send_item(make_pair('0, '0, ONE, '0));                    // resting
      send_item(make_pair('0, ONE, 32'd1, '0));                 // one-LSB distance
      send_item(make_pair(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN)); // widest gap, fastest
      send_item(make_pair(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX));
      send_item(make_pair(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN)); // coincident extremes
      send_item(make_pair(VAL_MIN, VAL_MAX, VAL_MIN + 1, VAL_MIN));
      send_item(make_pair(ONE, ONE, '0, '0));                   // second body behind
      send_item(make_pair(ONE, -ONE, '0, VAL_MAX));
      // diagonal approach in all three axes
      it = '0;
      for (int i = 0; i < 3; i++) begin
         it.pos2[i] = ONE;
         it.vel1[i] = ONE;
         it.vel2[i] = -ONE;
      end
      send_item(it);
      it.pos2[1] = -ONE;
      it.vel1 = {3{VAL_MAX}};
      it.vel2 = {3{VAL_MIN}};
      send_item(it);
      it.pos1 = {3{VAL_MAX}};
      it.pos2 = {3{VAL_MIN}};
      send_item(it);
      it.pos2[2] = VAL_MAX;
      send_item(it);
      // only y and z differ
      it = '0;
      it.pos2[1] = 32'd3;
      it.pos2[2] = -32'd4;
      it.vel1[1] = VAL_MAX;
      it.vel1[2] = VAL_MIN;
      send_item(it);
      send_item('1);
      send_item('0);
   endtask

   task automatic test_masses();
      // extremes, zero read as one, an unused index, then random values
      write_mass(REG_MASS_FIRST, 32'd1);
      write_mass(REG_MASS_SECOND, 32'd1);
      run_random(PHASE_ITEMS);
      write_mass(REG_MASS_FIRST, '1);
      run_random(PHASE_ITEMS);
      write_mass(REG_MASS_SECOND, '1);
      run_random(PHASE_ITEMS);
      write_mass(REG_MASS_FIRST, '0);
      write_mass(REG_UNUSED, 32'h1234_5678);
      run_random(PHASE_ITEMS);
      write_mass(REG_MASS_SECOND, '0);
      run_random(PHASE_ITEMS / 2);
      write_mass(REG_MASS_FIRST, $urandom);
      write_mass(REG_MASS_SECOND, $urandom_range(1, 1 << 20));
      run_random(PHASE_ITEMS);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      run_random(PHASE_ITEMS);
      test_masses();
      // drain, then let the pipeline fall silent
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_velocities.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ elastic_collision_response.f @@
rtl/core/ecr_pkg.sv
rtl/core/ecr_front.sv
rtl/core/ecr_queue.sv
rtl/core/ecr_ratio.sv
rtl/core/ecr_back.sv
rtl/core/elastic_collision_response.sv
dv/elastic_collision_response_tb.sv
